FILE: rtl/core/running_stats_welford_assert.svh
// Assertion macros for the running statistics RTL
`ifndef RUNNING_STATS_WELFORD_ASSERT_SVH
`define RUNNING_STATS_WELFORD_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RSW_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("running_stats_welford: check failed");

// next-cycle implication, checked outside reset
`define RSW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("running_stats_welford: check failed");

`endif

FILE: rtl/core/rsw_pkg.sv
// Shared constants and types for the running statistics block
`timescale 1ns / 1ps
package rsw_pkg;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 24;
    localparam int MEAN_FRAC_DEF    = 16;

    localparam int TOTAL_W  = 40;
    localparam int AVG_W    = 32;
    localparam int AVG_FRAC = 16;
    localparam int VAR_W    = 39;
    localparam int SD_W     = 24;
    localparam int RAD_W    = 2 * SD_W;
    localparam int VAR_FRAC = 8;
    localparam int SQ_W     = 64;
    localparam int DIV_W    = 64;
    localparam int STEP_W   = $clog2(DIV_W + 1);
    localparam int Q_DEPTH  = 2;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;
endpackage

FILE: rtl/core/running_stats_welford.sv
// Running statistics top level: count, sum, min, max, Welford mean, variance, sigma
// Input channel: i_in_valid / o_in_stall carry one beat of i_mode and i_sample;
// mode 0 adds the sample, mode 1 clears all statistics.
// Output channel: o_out_valid / i_out_stall carry one result beat per input beat,
// in order, holding the statistics after that item.
// Work per item: a clear or the first sample after a clear skips both divisions and
// the square root; an added sample runs the mean division, the variance division and
// the square root in turn; a sample ignored at full count skips the mean division.
// The shared one-bit-per-cycle divider and the bit-serial root do this work;
// items are worked one at a time.
// A two-beat queue in front lets the source run ahead while an item is at work,
// and a result register lets the next item start while a result waits.
// Reset (synchronous, active low) empties the queue, clears all statistics and
// drops o_out_valid. While i_out_stall is high the result beat holds, the back
// end waits with its next result, and o_in_stall rises once the queue is full.
`timescale 1ns / 1ps
`include "running_stats_welford_assert.svh"
module running_stats_welford #(
    parameter int SAMPLE_WIDTH   = rsw_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH    = rsw_pkg::COUNT_WIDTH_DEF,
    parameter int MEAN_FRAC_BITS = rsw_pkg::MEAN_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [COUNT_WIDTH-1:0]                o_sample_count,
    output logic signed [rsw_pkg::TOTAL_W-1:0]    o_total,
    output logic signed [SAMPLE_WIDTH-1:0]        o_smallest,
    output logic signed [SAMPLE_WIDTH-1:0]        o_largest,
    output logic signed [rsw_pkg::AVG_W-1:0]      o_average,
    output logic [rsw_pkg::VAR_W-1:0]             o_spread_sq,
    output logic [rsw_pkg::SD_W-1:0]              o_spread,
    output logic                                  o_saturated
);
    logic                           w_q_valid;
    logic                           w_q_pop;
    rsw_pkg::t_op                   w_q_op;
    logic signed [SAMPLE_WIDTH-1:0] w_q_sample;

    rsw_front #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_mode    (i_mode),
        .i_sample  (i_sample),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_op    (w_q_op),
        .o_q_sample(w_q_sample)
    );

    rsw_back #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .MEAN_FRAC_BITS(MEAN_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .o_q_pop       (w_q_pop),
        .i_q_op        (w_q_op),
        .i_q_sample    (w_q_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_sample_count(o_sample_count),
        .o_total       (o_total),
        .o_smallest    (o_smallest),
        .o_largest     (o_largest),
        .o_average     (o_average),
        .o_spread_sq   (o_spread_sq),
        .o_spread      (o_spread),
        .o_saturated   (o_saturated)
    );

    `RSW_ASSERT_NOW(a_sat_flag, o_out_valid, o_saturated == (o_sample_count == '1))
    `RSW_ASSERT_NOW(a_var_small, o_out_valid && (o_sample_count < COUNT_WIDTH'(2)), (o_spread_sq == '0) && (o_spread == '0))
    `RSW_ASSERT_NOW(a_empty_zero, o_out_valid && (o_sample_count == '0), (o_smallest == '0) && (o_largest == '0) && (o_average == '0) && (o_total == '0))
    `RSW_ASSERT_NOW(a_min_max, o_out_valid, o_smallest <= o_largest)
endmodule

FILE: rtl/core/rsw_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end
`timescale 1ns / 1ps
module rsw_front #(
    parameter int SAMPLE_WIDTH = rsw_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic                           o_q_valid,
    input  logic                           i_q_pop,
    output rsw_pkg::t_op                   o_q_op,
    output logic signed [SAMPLE_WIDTH-1:0] o_q_sample
);
    localparam int PTR_W = $clog2(rsw_pkg::Q_DEPTH);
    localparam int CNT_W = $clog2(rsw_pkg::Q_DEPTH + 1);

    rsw_pkg::t_op                   r_q_op [rsw_pkg::Q_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_q_x  [rsw_pkg::Q_DEPTH];
    logic [PTR_W-1:0]               r_wp;
    logic [PTR_W-1:0]               r_rp;
    logic [CNT_W-1:0]               r_cnt;
    logic                           w_push;
    logic                           w_pop;

    assign o_in_stall = (r_cnt == CNT_W'(rsw_pkg::Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_op     = r_q_op[r_rp];
    assign o_q_sample = r_q_x[r_rp];
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_q_pop && o_q_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q_op[r_wp] <= i_mode ? rsw_pkg::OP_CLEAR : rsw_pkg::OP_ADD;
            r_q_x[r_wp]  <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PTR_W'(rsw_pkg::Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PTR_W'(rsw_pkg::Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/core/rsw_div.sv
// Restoring divider, one quotient bit per cycle, left-aligned dividend
`timescale 1ns / 1ps
module rsw_div #(
    parameter int COUNT_WIDTH = rsw_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rsw_pkg::STEP_W-1:0]   i_steps,
    input  logic [rsw_pkg::DIV_W-1:0]    i_dividend,
    input  logic [COUNT_WIDTH-1:0]       i_divisor,
    output logic                         o_done,
    output logic [rsw_pkg::DIV_W-1:0]    o_quotient
);
    logic [rsw_pkg::DIV_W-1:0]  r_quo;
    logic [COUNT_WIDTH-1:0]     r_rem;
    logic [COUNT_WIDTH-1:0]     r_den;
    logic [rsw_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [COUNT_WIDTH:0]       w_sh;
    logic                       w_ge;

    assign w_sh       = {r_rem, r_quo[rsw_pkg::DIV_W-1]};
    assign w_ge       = (w_sh >= {1'b0, r_den});
    assign o_done     = r_done;
    assign o_quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[rsw_pkg::DIV_W-2:0], w_ge};
            r_rem <= w_ge ? COUNT_WIDTH'(w_sh - {1'b0, r_den}) : COUNT_WIDTH'(w_sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rsw_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: rtl/core/rsw_sqrt.sv
// Bit-serial floor square root, one root bit per cycle
`timescale 1ns / 1ps
module rsw_sqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rsw_pkg::RAD_W-1:0] i_radicand,
    output logic                      o_done,
    output logic [rsw_pkg::SD_W-1:0]  o_root
);
    localparam int SDW   = rsw_pkg::SD_W;
    localparam int CNT_W = $clog2(SDW + 1);

    logic [rsw_pkg::RAD_W-1:0] r_rad;
    logic [SDW:0]              r_rem;
    logic [SDW-1:0]            r_root;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [SDW+2:0]            w_sh;
    logic [SDW+2:0]            w_trial;
    logic                      w_ge;

    assign w_sh    = {r_rem, r_rad[rsw_pkg::RAD_W-1 -: 2]};
    assign w_trial = (SDW + 3)'({r_root, 2'b01});
    assign w_ge    = (w_sh >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[rsw_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? (SDW + 1)'(w_sh - w_trial) : (SDW + 1)'(w_sh);
            r_root <= {r_root[SDW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SDW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

FILE: rtl/core/rsw_back.sv
// Back end: statistics state, Welford update sequencer and result register
`timescale 1ns / 1ps
module rsw_back #(
    parameter int SAMPLE_WIDTH   = rsw_pkg::SAMPLE_WIDTH_DEF,
    parameter int COUNT_WIDTH    = rsw_pkg::COUNT_WIDTH_DEF,
    parameter int MEAN_FRAC_BITS = rsw_pkg::MEAN_FRAC_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_q_valid,
    output logic                                  o_q_pop,
    input  rsw_pkg::t_op                          i_q_op,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_q_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [COUNT_WIDTH-1:0]                o_sample_count,
    output logic signed [rsw_pkg::TOTAL_W-1:0]    o_total,
    output logic signed [SAMPLE_WIDTH-1:0]        o_smallest,
    output logic signed [SAMPLE_WIDTH-1:0]        o_largest,
    output logic signed [rsw_pkg::AVG_W-1:0]      o_average,
    output logic [rsw_pkg::VAR_W-1:0]             o_spread_sq,
    output logic [rsw_pkg::SD_W-1:0]              o_spread,
    output logic                                  o_saturated
);
    localparam int HW    = SAMPLE_WIDTH + MEAN_FRAC_BITS;
    localparam int MW    = HW + 1;
    localparam int PW    = 2 * HW;
    localparam int SHIFT = 2 * MEAN_FRAC_BITS - rsw_pkg::VAR_FRAC;
    localparam int DW    = rsw_pkg::DIV_W;
    localparam int SQW   = rsw_pkg::SQ_W;
    localparam int VW    = rsw_pkg::VAR_W;

    typedef enum logic [3:0] {
        S_IDLE, S_APPLY, S_MDIV, S_DIFF, S_MUL, S_ACC, S_VAR, S_VDIV, S_SQRT, S_OUT
    } t_state;

    t_state                              r_state;
    rsw_pkg::t_op                        r_op;
    logic signed [SAMPLE_WIDTH-1:0]      r_x;
    logic [COUNT_WIDTH-1:0]              r_count;
    logic signed [rsw_pkg::TOTAL_W-1:0]  r_sum;
    logic signed [SAMPLE_WIDTH-1:0]      r_min;
    logic signed [SAMPLE_WIDTH-1:0]      r_max;
    logic signed [MW-1:0]                r_mean;
    logic [SQW-1:0]                      r_sq;
    logic [HW-1:0]                       r_mag_a;
    logic [HW-1:0]                       r_mag_b;
    logic                                r_neg;
    logic [PW-1:0]                       r_prod;
    logic [VW-1:0]                       r_var;
    logic [rsw_pkg::SD_W-1:0]            r_sd;
    logic                                r_div_start;
    logic [rsw_pkg::STEP_W-1:0]          r_div_steps;
    logic [DW-1:0]                       r_div_num;
    logic [COUNT_WIDTH-1:0]              r_div_den;
    logic                                r_sqrt_start;
    logic [rsw_pkg::RAD_W-1:0]           r_rad;
    logic                                r_out_valid;
    logic [COUNT_WIDTH-1:0]              r_o_count;
    logic signed [rsw_pkg::TOTAL_W-1:0]  r_o_total;
    logic signed [SAMPLE_WIDTH-1:0]      r_o_min;
    logic signed [SAMPLE_WIDTH-1:0]      r_o_max;
    logic signed [rsw_pkg::AVG_W-1:0]    r_o_avg;
    logic [VW-1:0]                       r_o_var;
    logic [rsw_pkg::SD_W-1:0]            r_o_sd;
    logic                                r_o_sat;

    logic                                w_div_done;
    logic [DW-1:0]                       w_quo;
    logic                                w_sqrt_done;
    logic [rsw_pkg::SD_W-1:0]            w_root;
    logic signed [MW-1:0]                w_xs;
    logic signed [MW:0]                  w_diff_old;
    logic signed [MW:0]                  w_diff_new;
    logic [MW:0]                         w_mag_old;
    logic [MW:0]                         w_mag_new;
    logic signed [MW-1:0]                w_q_ext;
    logic signed [MW-1:0]                w_step;
    logic [SQW:0]                        w_acc;
    logic [VW-1:0]                       w_var_sat;
    logic                                w_full;
    logic                                w_empty;
    logic                                w_out_free;

    assign w_xs       = MW'(r_x) <<< MEAN_FRAC_BITS;
    assign w_diff_old = (MW + 1)'(w_xs) - (MW + 1)'(r_mean);
    assign w_diff_new = (MW + 1)'(w_xs) - (MW + 1)'(r_mean);
    assign w_mag_old  = w_diff_old[MW] ? (MW + 1)'(-w_diff_old) : (MW + 1)'(w_diff_old);
    assign w_mag_new  = w_diff_new[MW] ? (MW + 1)'(-w_diff_new) : (MW + 1)'(w_diff_new);
    assign w_q_ext    = signed'(MW'({1'b0, w_quo[HW-1:0]}));
    assign w_step     = r_neg ? (MW'(0) - w_q_ext) : w_q_ext;
    assign w_acc      = (SQW + 1)'(r_sq) + (SQW + 1)'(r_prod >> SHIFT);
    assign w_var_sat  = (w_quo[DW-1:VW] != '0) ? '1 : w_quo[VW-1:0];
    assign w_full     = (r_count == '1);
    assign w_empty    = (r_count == '0);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop    = (r_state == S_IDLE);

    rsw_div #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_div_start),
        .i_steps   (r_div_steps),
        .i_dividend(r_div_num),
        .i_divisor (r_div_den),
        .o_done    (w_div_done),
        .o_quotient(w_quo)
    );

    rsw_sqrt u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_sqrt_start),
        .i_radicand(r_rad),
        .o_done    (w_sqrt_done),
        .o_root    (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_sum        <= '0;
            r_min        <= '0;
            r_max        <= '0;
            r_mean       <= '0;
            r_sq         <= '0;
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_div_start  <= 1'b0;
            r_sqrt_start <= 1'b0;
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_op    <= i_q_op;
                        r_x     <= i_q_sample;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    if (r_op == rsw_pkg::OP_CLEAR) begin
                        r_count <= '0;
                        r_sum   <= '0;
                        r_min   <= '0;
                        r_max   <= '0;
                        r_mean  <= '0;
                        r_sq    <= '0;
                        r_state <= S_VAR;
                    end else if (w_full) begin
                        r_state <= S_VAR;
                    end else begin
                        r_min   <= (w_empty || r_x < r_min) ? r_x : r_min;
                        r_max   <= (w_empty || r_x > r_max) ? r_x : r_max;
                        r_sum   <= r_sum + rsw_pkg::TOTAL_W'(r_x);
                        r_count <= r_count + 1'b1;
                        if (w_empty) begin
                            r_mean  <= w_xs;
                            r_state <= S_VAR;
                        end else begin
                            r_mag_a     <= w_mag_old[HW-1:0];
                            r_neg       <= w_diff_old[MW];
                            r_div_num   <= {w_mag_old[HW-1:0], (DW - HW)'(0)};
                            r_div_den   <= r_count + 1'b1;
                            r_div_steps <= rsw_pkg::STEP_W'(HW);
                            r_div_start <= 1'b1;
                            r_state     <= S_MDIV;
                        end
                    end
                end
                S_MDIV: begin
                    if (w_div_done) begin
                        r_mean  <= r_mean + w_step;
                        r_state <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    r_mag_b <= w_mag_new[HW-1:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_mag_a * r_mag_b;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_sq    <= w_acc[SQW] ? '1 : w_acc[SQW-1:0];
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    if (r_count > COUNT_WIDTH'(1)) begin
                        r_div_num   <= r_sq;
                        r_div_den   <= r_count - 1'b1;
                        r_div_steps <= rsw_pkg::STEP_W'(DW);
                        r_div_start <= 1'b1;
                        r_state     <= S_VDIV;
                    end else begin
                        r_var   <= '0;
                        r_sd    <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_VDIV: begin
                    if (w_div_done) begin
                        r_var        <= w_var_sat;
                        r_rad        <= rsw_pkg::RAD_W'({w_var_sat, rsw_pkg::VAR_FRAC'(0)});
                        r_sqrt_start <= 1'b1;
                        r_state      <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_sd    <= w_root;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_count   <= r_count;
                        r_o_total   <= r_sum;
                        r_o_min     <= w_empty ? '0 : r_min;
                        r_o_max     <= w_empty ? '0 : r_max;
                        r_o_avg     <= w_empty ? '0 : rsw_pkg::AVG_W'(r_mean)
                                       <<< (rsw_pkg::AVG_FRAC - MEAN_FRAC_BITS);
                        r_o_var     <= r_var;
                        r_o_sd      <= r_sd;
                        r_o_sat     <= w_full;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_sample_count = r_o_count;
    assign o_total        = r_o_total;
    assign o_smallest     = r_o_min;
    assign o_largest      = r_o_max;
    assign o_average      = r_o_avg;
    assign o_spread_sq    = r_o_var;
    assign o_spread       = r_o_sd;
    assign o_saturated    = r_o_sat;
endmodule
